[hw/rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked check, disabled while the active-low reset is asserted
`define SVIE_CHECK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// check on the block clock and reset
`define SVIE_ASSERT(lbl, prop, msg) `SVIE_CHECK(lbl, clk, rst_n, prop, msg)

`endif

[hw/rtl/svie_pkg.sv]
// types, codes and constants of the script instruction executor
`timescale 1ns / 1ps
package svie_pkg;

  localparam int CONTEXTS_DEF   = 16;
  localparam int FLAG_COUNT_DEF = 256;

  // func codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_EXEC  = 2'd1;
  localparam logic [1:0] FUNC_FLAG  = 2'd2;

  // opcodes
  localparam logic [7:0] OP_STOP     = 8'd0;
  localparam logic [7:0] OP_SKIP_CLR = 8'd1;
  localparam logic [7:0] OP_SKIP_SET = 8'd2;
  localparam logic [7:0] OP_GOTO     = 8'd3;
  localparam logic [7:0] OP_LED_ON   = 8'd4;
  localparam logic [7:0] OP_LED_OFF  = 8'd5;
  localparam logic [7:0] OP_TIMER    = 8'd6;
  localparam logic [7:0] OP_ZONE     = 8'd7;
  localparam logic [7:0] OP_EVENT    = 8'd8;

  // action codes
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_DEVICE = 3'd1;
  localparam logic [2:0] ACT_TIMER  = 3'd2;
  localparam logic [2:0] ACT_ZONE   = 3'd3;
  localparam logic [2:0] ACT_EVENT  = 3'd4;

  localparam logic [7:0]  ERR_EVENT_CODE = 8'd33;
  localparam logic [5:0]  UNIT_MASK      = 6'h3F;
  localparam logic [15:0] PC_STEP        = 16'd4;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  context_req;
    logic [15:0] start_addr;
    logic [7:0]  opcode;
    logic [7:0]  arg1;
    logic [7:0]  arg2;
    logic [7:0]  arg3;
    logic [7:0]  flag_index;
    logic        flag_value;
  } item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [2:0]  action;
    logic [7:0]  act_a;
    logic [7:0]  act_b;
    logic [7:0]  act_c;
    logic [9:0]  zone_index;
  } result_t;

  // table and flag read data for the item in the input register
  typedef struct packed {
    logic        ctx_ok;
    logic [15:0] pc;
    logic [15:0] base;
    logic        flag;
  } rd_t;

  // state update caused by one item
  typedef struct packed {
    logic [3:0]  ctx;
    logic        pc_we;
    logic        base_we;
    logic [15:0] pc_val;
    logic        flag_we;
    logic [7:0]  flag_idx;
    logic        flag_val;
  } upd_t;

endpackage

[hw/rtl/svie_ctx_store.sv]
// context counter and base tables plus the flag store
`timescale 1ns / 1ps
module svie_ctx_store
  import svie_pkg::*;
#(
  parameter int CONTEXTS   = CONTEXTS_DEF,
  parameter int FLAG_COUNT = FLAG_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] rd_ctx,
  input  logic       rd_flag_en,
  input  logic [7:0] rd_flag_idx,
  input  upd_t       upd,
  output rd_t        rd
);

  localparam int CTX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int FI_W  = $clog2(FLAG_COUNT);

  logic [15:0]           pc_r   [CONTEXTS];
  logic [15:0]           base_r [CONTEXTS];
  logic [FLAG_COUNT-1:0] flag_r;
  logic                  flag_rd_r;
  logic                  flag_rd_nxt;
  logic                  flag_fwd;

  logic [CTX_W+3:0] rd_ctx_ext;
  logic [CTX_W+3:0] wr_ctx_ext;
  logic [CTX_W-1:0] rd_idx;
  logic [CTX_W-1:0] wr_idx;
  logic             rd_ok;
  logic             wr_ok;
  logic             rd_flag_ok;
  logic             wr_flag_ok;

  assign rd_ctx_ext = {{CTX_W{1'b0}}, rd_ctx};
  assign wr_ctx_ext = {{CTX_W{1'b0}}, upd.ctx};
  assign rd_idx     = rd_ctx_ext[CTX_W-1:0];
  assign wr_idx     = wr_ctx_ext[CTX_W-1:0];
  assign rd_ok      = ({28'd0, rd_ctx} < CONTEXTS);
  assign wr_ok      = ({28'd0, upd.ctx} < CONTEXTS);
  assign rd_flag_ok = ({24'd0, rd_flag_idx} < FLAG_COUNT);
  assign wr_flag_ok = ({24'd0, upd.flag_idx} < FLAG_COUNT);

  // a flag written on the edge that loads the read takes the new value
  assign flag_fwd = upd.flag_we && wr_flag_ok && (upd.flag_idx == rd_flag_idx);

  always_comb begin
    flag_rd_nxt = rd_flag_ok ? flag_r[rd_flag_idx[FI_W-1:0]] : 1'b0;
    if (flag_fwd) begin
      flag_rd_nxt = upd.flag_val;
    end
  end

  always_comb begin
    rd.ctx_ok = rd_ok;
    rd.pc     = rd_ok ? pc_r[rd_idx] : 16'd0;
    rd.base   = rd_ok ? base_r[rd_idx] : 16'd0;
    rd.flag   = flag_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CONTEXTS; i++) begin
        pc_r[i]   <= '0;
        base_r[i] <= '0;
      end
      flag_r    <= '0;
      flag_rd_r <= 1'b0;
    end else begin
      if (upd.pc_we && wr_ok) begin
        pc_r[wr_idx] <= upd.pc_val;
      end
      if (upd.base_we && wr_ok) begin
        base_r[wr_idx] <= upd.pc_val;
      end
      if (upd.flag_we && wr_flag_ok) begin
        flag_r[upd.flag_idx[FI_W-1:0]] <= upd.flag_val;
      end
      if (rd_flag_en) begin
        flag_rd_r <= flag_rd_nxt;
      end
    end
  end

endmodule

[hw/rtl/svie_exec.sv]
// instruction decode and execute for one item
`timescale 1ns / 1ps
module svie_exec
  import svie_pkg::*;
(
  input  item_t   item,
  input  rd_t     rd,
  input  logic    is_master,
  output result_t res,
  output upd_t    upd
);

  logic [15:0] pc_adv;
  logic [15:0] pc_new;
  logic [15:0] goto_off;

  assign pc_adv   = rd.pc + PC_STEP;
  assign goto_off = {item.arg2[5:0], item.arg1, 2'b00};

  always_comb begin
    res          = '0;
    upd          = '0;
    upd.ctx      = item.context_req;
    pc_new       = pc_adv;
    if (rd.ctx_ok) begin
      res.next_pc = rd.pc;
      unique case (item.func)
        FUNC_START: begin
          upd.pc_we   = 1'b1;
          upd.base_we = 1'b1;
          upd.pc_val  = item.start_addr;
          res.next_pc = item.start_addr;
        end
        FUNC_FLAG: begin
          upd.flag_we  = 1'b1;
          upd.flag_idx = item.flag_index;
          upd.flag_val = item.flag_value;
        end
        FUNC_EXEC: begin
          // an inactive context stays as it is
          if (rd.pc != 16'd0) begin
            unique case (item.opcode)
              OP_STOP: pc_new = 16'd0;
              OP_SKIP_CLR: begin
                if (!rd.flag) pc_new = pc_adv + PC_STEP;
              end
              OP_SKIP_SET: begin
                if (rd.flag) pc_new = pc_adv + PC_STEP;
              end
              OP_GOTO: pc_new = rd.base + goto_off;
              OP_LED_ON, OP_LED_OFF: begin
                if (is_master) begin
                  res.action = ACT_DEVICE;
                  res.act_a  = {2'b00, item.arg1[5:0] & UNIT_MASK};
                  res.act_b  = {2'b00, item.arg2[5:0] & UNIT_MASK};
                  res.act_c  = {7'd0, (item.opcode == OP_LED_ON)};
                end
              end
              OP_TIMER: begin
                res.action = ACT_TIMER;
                res.act_a  = item.arg1;
                res.act_b  = item.arg2;
                if (item.arg2 != 8'd0) begin
                  res.act_c    = item.arg3;
                  upd.flag_we  = 1'b1;
                  upd.flag_idx = item.arg3;
                  upd.flag_val = 1'b0;
                end
              end
              OP_ZONE: begin
                res.action     = ACT_ZONE;
                res.zone_index = {item.arg1, 2'b00} | {2'b00, item.arg2};
              end
              OP_EVENT: begin
                res.action = ACT_EVENT;
                res.act_a  = item.arg1;
                res.act_b  = item.arg2;
              end
              default: begin
                // unknown opcode halts the context and reports it
                pc_new     = 16'd0;
                res.action = ACT_EVENT;
                res.act_a  = ERR_EVENT_CODE;
                res.act_b  = {4'd0, item.context_req};
              end
            endcase
            upd.pc_we   = 1'b1;
            upd.pc_val  = pc_new;
            res.next_pc = pc_new;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/script_vm_instruction_executor_unit.sv]
// top level of the script instruction executor
//
//  port group | dir | carries
//  in_*       | in  | request: tuser func, tdata context/start/instr/flag fields
//  out_*      | out | result: next counter and one external action
//  cfg_*      | in  | is_master register write
//
// one item per cycle sustained while out_tready is high; out_tvalid rises as the
// item moves from the input register, where it executes, to the result register;
// its table/flag writes land on the edge that loads the result register. the skip
// flag is read on entry to the input register, a same-edge flag write forwarded
// a stalled output holds the result and the input register; in_tready drops only
// when both are full. synchronous active-low reset clears state and sets is_master
`timescale 1ns / 1ps
module script_vm_instruction_executor_unit
  import svie_pkg::*;
#(
  parameter int CONTEXTS   = CONTEXTS_DEF,
  parameter int FLAG_COUNT = FLAG_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // context_req[3:0] start_addr[19:4] opcode[27:20] arg1[35:28] arg2[43:36]
  // arg3[51:44] flag_index[59:52] flag_value[60] zero[63:61]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // next_pc[15:0] action[18:16] act_a[26:19] act_b[34:27] act_c[42:35]
  // zone_index[52:43] zero[55:53]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata
);

  item_t   in_item;
  item_t   item_r;
  logic    item_valid_r;
  result_t res_r;
  result_t res_nxt;
  logic    out_valid_r;
  logic    is_master_r;
  logic    advance;
  rd_t     rd;
  upd_t    upd_raw;
  upd_t    upd;
  logic    res_none;
  logic    res_no_payload;
  logic    upd_any_we;

  always_comb begin
    in_item.func        = in_tuser;
    in_item.context_req = in_tdata[3:0];
    in_item.start_addr  = in_tdata[19:4];
    in_item.opcode      = in_tdata[27:20];
    in_item.arg1        = in_tdata[35:28];
    in_item.arg2        = in_tdata[43:36];
    in_item.arg3        = in_tdata[51:44];
    in_item.flag_index  = in_tdata[59:52];
    in_item.flag_value  = in_tdata[60];
  end

  // the executing item moves into the result register
  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;

  svie_ctx_store #(
    .CONTEXTS   (CONTEXTS),
    .FLAG_COUNT (FLAG_COUNT)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_ctx      (item_r.context_req),
    .rd_flag_en  (in_tvalid && in_tready),
    .rd_flag_idx (in_item.arg1),
    .upd         (upd),
    .rd          (rd)
  );

  svie_exec u_exec (
    .item      (item_r),
    .rd        (rd),
    .is_master (is_master_r),
    .res       (res_nxt),
    .upd       (upd_raw)
  );

  always_comb begin
    upd         = upd_raw;
    upd.pc_we   = upd_raw.pc_we && advance;
    upd.base_we = upd_raw.base_we && advance;
    upd.flag_we = upd_raw.flag_we && advance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      is_master_r  <= 1'b1;
    end else begin
      if (in_tvalid && in_tready) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        is_master_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, res_r.zone_index, res_r.act_c, res_r.act_b, res_r.act_a,
                       res_r.action, res_r.next_pc};

  assign res_none       = out_valid_r && (res_r.action == ACT_NONE);
  assign res_no_payload = ({res_r.act_a, res_r.act_b, res_r.act_c, res_r.zone_index} == 34'd0);
  assign upd_any_we     = upd.pc_we || upd.base_we || upd.flag_we;

`include "assert_macros.svh"

  `SVIE_ASSERT(a_accept_fills, in_tvalid && in_tready |=> item_valid_r, "accepted item lost")
  `SVIE_ASSERT(a_stall_keeps_item, item_valid_r && !advance |=> item_valid_r, "stalled item dropped")
  `SVIE_ASSERT(a_none_is_zero, res_none |-> res_no_payload, "action none with payload")
  `SVIE_ASSERT(a_no_write_idle, !advance |-> !upd_any_we, "state write without transfer")

endmodule
